// ===== rtl/stable_priority_queue_defines.svh =====
// Assertion macros shared by the stable priority queue RTL.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the stable priority queue.
// No dependencies; imported by the interfaces, the controller, the datapath and the top module.
package spq_pkg;

  // Number of priority levels and the width of a level code.
  localparam int unsigned NumLevels = 3;
  localparam int unsigned LvlW      = 2;
  localparam int unsigned OccW      = 8;

  // Least urgent level; an urgency of three is folded onto it.
  localparam logic [LvlW-1:0] LvlLeast = 2'd2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECIDE = 2'd1,
    S_READ   = 2'd2,
    S_RESULT = 2'd3
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    push;
    logic    pop;
    logic    load_result;
    status_e result_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
  } sts_t;

endpackage

// ===== rtl/spq_in_if.sv =====
// Request channel of the stable priority queue: valid, ready and one request beat.
// Depends on spq_pkg for the field widths.
interface spq_in_if import spq_pkg::*; #(
  parameter int unsigned TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [TAG_WIDTH-1:0] item_tag;
  logic [LvlW-1:0]      urgency;

  modport source (output valid, output action, output item_tag, output urgency,
                  input ready);
  modport sink   (input valid, input action, input item_tag, input urgency,
                  output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
// Response channel of the stable priority queue: valid, ready and one response beat.
// Depends on spq_pkg for the field widths.
interface spq_out_if import spq_pkg::*; #(
  parameter int unsigned TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TAG_WIDTH-1:0] out_tag;
  logic [LvlW-1:0]      out_urgency;
  logic [OccW-1:0]      occupancy;

  modport source (output valid, output status, output out_tag, output out_urgency,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_tag, input out_urgency,
                  input occupancy, output ready);
endinterface

// ===== rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller of the stable priority queue: sequences one request at a time.
// Depends on spq_pkg for the state, command and status types.
module spq_ctrl import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  status_e     code_q, code_d;
  logic        out_valid_q, out_valid_d;

  // State, result code and response valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= ST_INSERTED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d           = state_q;
    code_d            = code_q;
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.result_code = code_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_RESULT;
        if (!sts_i.is_remove) begin
          if (sts_i.full) begin
            code_d = ST_FULL;
          end else begin
            code_d     = ST_INSERTED;
            cmd_o.push = 1'b1;
          end
        end else if (sts_i.empty) begin
          code_d = ST_EMPTY;
        end else begin
          code_d    = ST_REMOVED;
          cmd_o.pop = 1'b1;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        // The RAM registered the head entry at the end of the decide step;
        // this step only waits before the result is loaded.
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The response register fills on a load and drains on a taken beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath of the stable priority queue: one FIFO per level in RAM plus counters.
// Depends on spq_pkg and spq_ram.
module spq_datapath import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 action_i,
  input  logic [TAG_WIDTH-1:0] item_tag_i,
  input  logic [LvlW-1:0]      urgency_i,
  output logic [1:0]           status_o,
  output logic [TAG_WIDTH-1:0] out_tag_o,
  output logic [LvlW-1:0]      out_urgency_o,
  output logic [OccW-1:0]      occupancy_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  // Captured request.
  logic                 action_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [LvlW-1:0]      lvl_q;

  // Per-level FIFO pointers and fill counts, plus the total fill.
  logic [PtrW-1:0] head_q [NumLevels];
  logic [PtrW-1:0] tail_q [NumLevels];
  logic [CntW-1:0] lvl_cnt_q [NumLevels];
  logic [CntW-1:0] cnt_q;

  logic [LvlW-1:0]      sel_lvl;
  logic [LvlW-1:0]      pop_lvl_q;
  logic [TAG_WIDTH-1:0] rd_data [NumLevels];
  logic [TAG_WIDTH-1:0] head_tag;

  // Result register.
  logic [1:0]           status_q;
  logic [TAG_WIDTH-1:0] out_tag_q;
  logic [LvlW-1:0]      out_urg_q;
  logic [OccW-1:0]      occ_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // Capture the request; urgency three is folded onto the least urgent level.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      tag_q    <= item_tag_i;
      lvl_q    <= (urgency_i > LvlLeast) ? LvlLeast : urgency_i;
    end
  end

  // The head of the queue is the front of the most urgent non-empty level.
  always_comb begin
    priority if (lvl_cnt_q[0] != '0) begin
      sel_lvl = 2'd0;
    end else if (lvl_cnt_q[1] != '0) begin
      sel_lvl = 2'd1;
    end else begin
      sel_lvl = LvlLeast;
    end
  end

  // Pointer and count updates on a push or a pop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i]    <= '0;
        tail_q[i]    <= '0;
        lvl_cnt_q[i] <= '0;
      end
      cnt_q     <= '0;
      pop_lvl_q <= '0;
    end else if (cmd_i.push) begin
      tail_q[lvl_q]    <= ptr_next(tail_q[lvl_q]);
      lvl_cnt_q[lvl_q] <= lvl_cnt_q[lvl_q] + 1'b1;
      cnt_q            <= cnt_q + 1'b1;
    end else if (cmd_i.pop) begin
      head_q[sel_lvl]    <= ptr_next(head_q[sel_lvl]);
      lvl_cnt_q[sel_lvl] <= lvl_cnt_q[sel_lvl] - 1'b1;
      cnt_q              <= cnt_q - 1'b1;
      pop_lvl_q          <= sel_lvl;
    end
  end

  // One tag store per level.
  for (genvar g = 0; g < NumLevels; g++) begin : g_level
    spq_ram #(
      .WIDTH (TAG_WIDTH),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (cmd_i.push && (lvl_q == LvlW'(g))),
      .wr_addr_i (tail_q[g]),
      .wr_data_i (tag_q),
      .rd_en_i   (cmd_i.pop && (sel_lvl == LvlW'(g))),
      .rd_addr_i (head_q[g]),
      .rd_data_o (rd_data[g])
    );
  end

  assign head_tag = rd_data[pop_lvl_q];

  // Load the response beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q <= cmd_i.result_code;
      occ_q    <= OccW'(cnt_q);
      if (cmd_i.result_code == ST_REMOVED) begin
        out_tag_q <= head_tag;
        out_urg_q <= pop_lvl_q;
      end else begin
        out_tag_q <= '0;
        out_urg_q <= '0;
      end
    end
  end

  assign sts_o.is_remove = (action_q == ACT_REMOVE);
  assign sts_o.full      = (cnt_q == CntFull);
  assign sts_o.empty     = (cnt_q == '0);

  assign status_o      = status_q;
  assign out_tag_o     = out_tag_q;
  assign out_urgency_o = out_urg_q;
  assign occupancy_o   = occ_q;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Channel  Dir  Beat contents
// in_i     in   action, item_tag, urgency
// out_o    out  status, out_tag, out_urgency, occupancy
//
// A request is taken only in the idle state: an insert or a refused request
// passes the decide and result steps before its response beat, a remove also
// the read step: one wait step after the registered head read of the level RAMs.
// The next request is taken while the previous response still waits in the
// output register; a stalled response holds the controller in its result step.
// Reset empties the queue at once by clearing the pointers and counts.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Storage and counters.
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (in_i.action),
    .item_tag_i    (in_i.item_tag),
    .urgency_i     (in_i.urgency),
    .status_o      (out_o.status),
    .out_tag_o     (out_o.out_tag),
    .out_urgency_o (out_o.out_urgency),
    .occupancy_o   (out_o.occupancy)
  );

  // An insert is never written into a full queue.
  `SPQ_ASSERT_ALWAYS(a_no_push_full, !(cmd.push && sts.full), "push while full")
  // A remove never reads from an empty queue.
  `SPQ_ASSERT_ALWAYS(a_no_pop_empty, !(cmd.pop && sts.empty), "pop while empty")
  // After a request is taken the block is busy in the next cycle.
  `SPQ_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "busy")

endmodule
